// ===== rtl/ccfc_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN command channel package
// Shared types, codes and helpers for the CAN command frame channel.
// ----------------------------------------------------------------------------
package ccfc_pkg;

    localparam int ENTRY_SLOTS_DEFAULT = 16;
    localparam int QUEUE_DEPTH         = 2;

    localparam int HEAD_EMPTY_BIT = 7;
    localparam logic [7:0] TYPE_MASK  = 8'b0111_1111;
    localparam logic [7:0] EMPTY_FLAG = 8'b1000_0000;

    // Received frame lengths that carry an entry.
    localparam logic [3:0] FRAME_LEN_EMPTY = 4'd1;
    localparam logic [3:0] FRAME_LEN_FULL  = 4'd5;

    // Outgoing frame lengths.
    localparam logic [2:0] TX_LEN_NONE  = 3'd0;
    localparam logic [2:0] TX_LEN_EMPTY = 3'd1;
    localparam logic [2:0] TX_LEN_FULL  = 3'd5;

    // Receive event codes.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_BAD     = 3'd1;
    localparam logic [2:0] EV_DROP    = 3'd2;
    localparam logic [2:0] EV_HEADER  = 3'd3;
    localparam logic [2:0] EV_STORED  = 3'd4;

    // Header entry type.
    localparam logic [6:0] TYPE_HEADER = 7'd0;

    // Configuration register indexes.
    localparam logic [1:0] REG_TX_COMMAND_ID  = 2'd0;
    localparam logic [1:0] REG_TX_TARGET      = 2'd1;
    localparam logic [1:0] REG_TX_SOURCE      = 2'd2;
    localparam logic [1:0] REG_TX_ENTRY_COUNT = 2'd3;

    typedef enum logic [1:0] {
        ACT_RECEIVE = 2'd0,
        ACT_FETCH   = 2'd1,
        ACT_WRITE   = 2'd2,
        ACT_CANCEL  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OP_RX_BAD,
        OP_RX_HEADER,
        OP_RX_ENTRY,
        OP_FETCH,
        OP_WRITE,
        OP_CANCEL
    } op_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        op_t         op;
        logic [7:0]  frame_id;
        logic [6:0]  kind;
        logic [31:0] word;
        logic [3:0]  slot;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [7:0]  head;
        logic [31:0] payload;
    } tx_frame_t;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic        sending_busy;
        logic        receiving_busy;
        logic [4:0]  tx_remaining;
        logic [31:0] tx_payload;
        logic [7:0]  tx_head;
        logic [2:0]  tx_len;
        logic [7:0]  tx_frame_id;
        logic [31:0] rx_value;
        logic [6:0]  rx_type;
        logic [3:0]  rx_index;
        logic        rx_complete;
        logic [2:0]  rx_event;
    } result_t;

    // An entry whose word is zero goes out as a one-byte frame.
    function automatic tx_frame_t emit_entry(input logic [6:0] kind, input logic [31:0] word);
        tx_frame_t f;
        if (word == 32'd0)
        begin
            f.len     = TX_LEN_EMPTY;
            f.head    = {1'b0, kind} | EMPTY_FLAG;
            f.payload = 32'd0;
        end
        else
        begin
            f.len     = TX_LEN_FULL;
            f.head    = {1'b0, kind} & TYPE_MASK;
            f.payload = word;
        end
        return f;
    endfunction

endpackage

// ===== rtl/ccfc_front.sv =====
// ----------------------------------------------------------------------------
// CAN command channel front end
// Checks received frames and classifies each input item into a command.
// ----------------------------------------------------------------------------
module ccfc_front (
    input  logic [1:0]     action,
    input  logic [7:0]     frame_id,
    input  logic [3:0]     frame_len,
    input  logic [7:0]     frame_head,
    input  logic [31:0]    frame_payload,
    input  logic [3:0]     entry_slot,
    input  logic [6:0]     entry_kind,
    input  logic [31:0]    entry_word,
    output ccfc_pkg::cmd_t cmd
);
    import ccfc_pkg::*;

    logic       head_empty;
    logic [6:0] head_type;
    logic       frame_full_ok;
    logic       frame_empty_ok;

    assign head_empty     = frame_head[HEAD_EMPTY_BIT];
    assign head_type      = frame_head[6:0];
    assign frame_full_ok  = (frame_len == FRAME_LEN_FULL) && !head_empty;
    assign frame_empty_ok = (frame_len == FRAME_LEN_EMPTY) && head_empty;

    always_comb
    begin
        cmd          = '0;
        cmd.frame_id = frame_id;
        cmd.slot     = entry_slot;
        unique case (action_t'(action))
            ACT_RECEIVE:
            begin
                cmd.kind = head_type;
                if (!frame_full_ok && !frame_empty_ok)
                begin
                    cmd.op = OP_RX_BAD;
                end
                else
                begin
                    // A one-byte frame decodes to a zero value.
                    cmd.word = frame_full_ok ? frame_payload : 32'd0;
                    cmd.op   = (head_type == TYPE_HEADER) ? OP_RX_HEADER : OP_RX_ENTRY;
                end
            end
            ACT_FETCH:
            begin
                cmd.op = OP_FETCH;
            end
            ACT_WRITE:
            begin
                cmd.op   = OP_WRITE;
                cmd.kind = entry_kind;
                cmd.word = entry_word;
            end
            ACT_CANCEL:
            begin
                cmd.op = OP_CANCEL;
            end
        endcase
    end

endmodule

// ===== rtl/ccfc_queue.sv =====
// ----------------------------------------------------------------------------
// CAN command channel queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ccfc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ccfc_pkg::cmd_t push_cmd,
    output logic           not_full,
    input  logic           pop,
    output logic           not_empty,
    output ccfc_pkg::cmd_t head_cmd
);
    import ccfc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/ccfc_back.sv =====
// ----------------------------------------------------------------------------
// CAN command channel back end
// Holds the channel state, transmit entry store and configuration registers,
// runs one command per cycle unless the output stalls, registering the result.
// ----------------------------------------------------------------------------
module ccfc_back #(
    parameter int ENTRY_SLOTS = ccfc_pkg::ENTRY_SLOTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  ccfc_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              res_valid,
    input  logic              res_ready,
    output ccfc_pkg::result_t res
);
    import ccfc_pkg::*;

    localparam int POS_W = $clog2(ENTRY_SLOTS + 1);
    localparam int IDX_W = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;

    // Configuration registers.
    logic [7:0] tx_command_id_reg;
    logic [7:0] tx_target_reg;
    logic [7:0] tx_source_reg;
    logic [4:0] tx_entry_count_reg;

    // Channel state.
    logic             rx_open_reg, rx_open_next;
    logic [POS_W-1:0] rx_position_reg, rx_position_next;
    logic [7:0]       rx_command_id_reg, rx_command_id_next;
    logic [7:0]       rx_expected_reg, rx_expected_next;
    logic             tx_open_reg, tx_open_next;
    logic [POS_W-1:0] tx_position_reg, tx_position_next;

    // Transmit entry store, undefined until written.
    logic [6:0]  store_kind [ENTRY_SLOTS];
    logic [31:0] store_word [ENTRY_SLOTS];

    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     res_next;
    logic        store_we;

    logic [CMP_W-1:0] slots_c;
    logic [CMP_W-1:0] rx_pos_ext, rx_pos_inc, rx_expected_ext;
    logic [CMP_W-1:0] tx_pos_ext, tx_pos_inc, tx_count_ext, tx_left;
    logic [CMP_W-1:0] slot_ext;
    logic [IDX_W-1:0] rd_idx, wr_idx;
    logic [31:0]      tx_header_word;
    tx_frame_t        frame;

    assign cfg_ready = 1'b1;
    assign cmd_pop   = cmd_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    assign slots_c         = CMP_W'(ENTRY_SLOTS);
    assign rx_pos_ext      = CMP_W'(rx_position_reg);
    assign rx_pos_inc      = rx_pos_ext + 1'b1;
    assign rx_expected_ext = CMP_W'(rx_expected_reg);
    assign tx_pos_ext      = CMP_W'(tx_position_reg);
    assign tx_pos_inc      = tx_pos_ext + 1'b1;
    assign tx_count_ext    = CMP_W'(tx_entry_count_reg);
    assign tx_left         = tx_count_ext - tx_pos_inc;
    assign slot_ext        = CMP_W'(cmd.slot);
    assign rd_idx          = tx_position_reg[IDX_W-1:0];
    assign wr_idx          = slot_ext[IDX_W-1:0];
    assign tx_header_word  = {3'b000, tx_entry_count_reg, tx_source_reg,
                              tx_target_reg, tx_command_id_reg};

    always_comb
    begin
        rx_open_next       = rx_open_reg;
        rx_position_next   = rx_position_reg;
        rx_command_id_next = rx_command_id_reg;
        rx_expected_next   = rx_expected_reg;
        tx_open_next       = tx_open_reg;
        tx_position_next   = tx_position_reg;
        store_we           = 1'b0;
        frame              = '0;
        res_next           = '0;

        unique case (cmd.op)
            OP_RX_BAD:
            begin
                res_next.rx_event = EV_BAD;
                res_next.rx_type  = cmd.kind;
            end
            OP_RX_HEADER:
            begin
                res_next.rx_event  = EV_HEADER;
                res_next.rx_type   = cmd.kind;
                res_next.rx_value  = cmd.word;
                rx_command_id_next = cmd.word[7:0];
                rx_expected_next   = cmd.word[31:24];
                rx_position_next   = '0;
                rx_open_next       = 1'b1;
                // A header that announces no entries closes at once.
                if (cmd.word[31:24] == 8'd0)
                begin
                    rx_open_next         = 1'b0;
                    res_next.rx_complete = 1'b1;
                end
            end
            OP_RX_ENTRY:
            begin
                res_next.rx_type  = cmd.kind;
                res_next.rx_value = cmd.word;
                if (!rx_open_reg || (cmd.frame_id != rx_command_id_reg) ||
                    (rx_pos_ext >= slots_c))
                begin
                    rx_open_next      = 1'b0;
                    res_next.rx_event = EV_DROP;
                end
                else
                begin
                    res_next.rx_event = EV_STORED;
                    res_next.rx_index = rx_pos_ext[3:0];
                    rx_position_next  = rx_position_reg + 1'b1;
                    if (rx_pos_inc == rx_expected_ext)
                    begin
                        rx_open_next         = 1'b0;
                        res_next.rx_complete = 1'b1;
                    end
                end
            end
            OP_FETCH:
            begin
                res_next.tx_frame_id = tx_command_id_reg;
                if (rx_open_reg)
                begin
                    // Sending waits while a received command is open.
                    res_next.tx_remaining = tx_entry_count_reg;
                end
                else if (!tx_open_reg)
                begin
                    frame            = emit_entry(TYPE_HEADER, tx_header_word);
                    tx_position_next = '0;
                    if (tx_entry_count_reg == 5'd0)
                    begin
                        tx_open_next = 1'b0;
                    end
                    else
                    begin
                        tx_open_next          = 1'b1;
                        res_next.tx_remaining = tx_entry_count_reg;
                    end
                end
                else if ((tx_pos_ext >= tx_count_ext) || (tx_pos_ext >= slots_c))
                begin
                    tx_open_next = 1'b0;
                end
                else
                begin
                    frame            = emit_entry(store_kind[rd_idx], store_word[rd_idx]);
                    tx_position_next = tx_position_reg + 1'b1;
                    if (tx_pos_inc >= tx_count_ext)
                    begin
                        tx_open_next = 1'b0;
                    end
                    else
                    begin
                        res_next.tx_remaining = tx_left[4:0];
                    end
                end
            end
            OP_WRITE:
            begin
                store_we = (slot_ext < slots_c);
            end
            OP_CANCEL:
            begin
                tx_open_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        res_next.tx_len         = frame.len;
        res_next.tx_head        = frame.head;
        res_next.tx_payload     = frame.payload;
        res_next.receiving_busy = rx_open_next;
        res_next.sending_busy   = tx_open_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_command_id_reg  <= '0;
            tx_target_reg      <= '0;
            tx_source_reg      <= '0;
            tx_entry_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TX_COMMAND_ID:  tx_command_id_reg  <= cfg_data;
                REG_TX_TARGET:      tx_target_reg      <= cfg_data;
                REG_TX_SOURCE:      tx_source_reg      <= cfg_data;
                REG_TX_ENTRY_COUNT: tx_entry_count_reg <= cfg_data[4:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_open_reg       <= 1'b0;
            rx_position_reg   <= '0;
            rx_command_id_reg <= '0;
            rx_expected_reg   <= '0;
            tx_open_reg       <= 1'b0;
            tx_position_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                rx_open_reg       <= rx_open_next;
                rx_position_reg   <= rx_position_next;
                rx_command_id_reg <= rx_command_id_next;
                rx_expected_reg   <= rx_expected_next;
                tx_open_reg       <= tx_open_next;
                tx_position_reg   <= tx_position_next;
                out_valid_reg     <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_data_reg <= res_next;
        end
        if (cmd_pop && store_we)
        begin
            store_kind[wr_idx] <= cmd.kind;
            store_word[wr_idx] <= cmd.word;
        end
    end

`ifndef SYNTHESIS
    a_complete_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.rx_complete) |-> !out_data_reg.receiving_busy)
        else $error("completed receive left the command open");

    a_tx_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_position_reg <= POS_W'(ENTRY_SLOTS))
        else $error("transmit position past capacity");

    a_fetch_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && (cmd.op == OP_FETCH) && rx_open_reg)
        |=> (out_valid_reg && (out_data_reg.tx_len == TX_LEN_NONE)))
        else $error("frame sent while a receive was open");

    a_remaining_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.tx_remaining != 5'd0) &&
         !out_data_reg.receiving_busy) |-> out_data_reg.sending_busy)
        else $error("entries left to send but sending is closed");
`endif

endmodule

// ===== rtl/can_command_frame_channel.sv =====
// ----------------------------------------------------------------------------
// CAN command frame channel
// Half-duplex command channel carrying one entry per short CAN frame.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel: s_axis_tuser selects receive
// frame, fetch next transmit frame, write transmit entry or cancel sending,
// and s_axis_tdata carries the frame and entry fields. Every item produces
// exactly one result transfer on the m_axis channel, in order.
// Configuration writes use the cfg channel (index 0 command id, 1 target,
// 2 source, 3 entry count) and are always accepted.
// The front end classifies the item as it is written into the command
// queue, and the back end takes it from the queue head, updates the channel
// state and registers the result in its output register.
// Throughput is one item per cycle while m_axis_tready does not stall the
// output, set by the back end, which executes one command per cycle.
// Reset closes receive and send, clears the configuration registers and
// empties the queue; transmit entries are undefined until written.
// When the receiver stalls, the output register holds its result, the
// two-entry queue fills and s_axis_tready then drops until space frees up.
// ----------------------------------------------------------------------------
module can_command_frame_channel #(
    parameter int ENTRY_SLOTS = ccfc_pkg::ENTRY_SLOTS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // frame_id[7:0], frame_len[11:8], frame_head[19:12], frame_payload[51:20],
    // entry_slot[55:52], entry_kind[62:56], entry_word[94:63], zero[95]
    input  logic [95:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rx_event[2:0], rx_complete[3], rx_index[7:4], rx_type[14:8],
    // rx_value[46:15], tx_frame_id[54:47], tx_len[57:55], tx_head[65:58],
    // tx_payload[97:66], tx_remaining[102:98], receiving_busy[103],
    // sending_busy[104], zero[111:105]
    output logic [111:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);
    import ccfc_pkg::*;

    cmd_t    front_cmd;
    cmd_t    queue_cmd;
    logic    queue_not_full;
    logic    queue_not_empty;
    logic    queue_pop;
    logic    push;
    result_t result;

    assign s_axis_tready = queue_not_full;
    assign push          = s_axis_tvalid && queue_not_full;
    assign m_axis_tdata  = {7'd0, result};

    ccfc_front u_front (
        .action        (s_axis_tuser),
        .frame_id      (s_axis_tdata[7:0]),
        .frame_len     (s_axis_tdata[11:8]),
        .frame_head    (s_axis_tdata[19:12]),
        .frame_payload (s_axis_tdata[51:20]),
        .entry_slot    (s_axis_tdata[55:52]),
        .entry_kind    (s_axis_tdata[62:56]),
        .entry_word    (s_axis_tdata[94:63]),
        .cmd           (front_cmd)
    );

    ccfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .not_full  (queue_not_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_cmd  (queue_cmd)
    );

    ccfc_back #(
        .ENTRY_SLOTS (ENTRY_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_not_empty),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (result)
    );

endmodule
